### design/open_addressing_hash_table_defines.svh
// assertion helpers used by oaht_back
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/oaht_pkg.sv
`default_nettype none
package oaht_pkg;

   localparam int TABLE_SLOTS   = 16;
   localparam int MAX_KEY_BYTES = 8;
   localparam int IDX_W         = $clog2(TABLE_SLOTS);
   localparam int CNT_W         = $clog2(TABLE_SLOTS + 1);
   localparam int USED_W        = CNT_W + 1 + 7;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
   // prime is 2^40 + 0x1b3
   localparam int          FNV_SHIFT    = 40;
   localparam logic [63:0] FNV_PRIME_LO = 64'h1b3;

   localparam logic [6:0] LIMIT_RESET = 7'd70;
   localparam logic [6:0] PCT_SCALE   = 7'd100;

   localparam logic [1:0] ACT_GET    = 2'd0;
   localparam logic [1:0] ACT_PUT    = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [1:0] SLOT_INVALID = 2'd0;
   localparam logic [1:0] SLOT_VALID   = 2'd1;
   localparam logic [1:0] SLOT_TOMB    = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key_bytes;
      logic [3:0]  key_length;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] value_out;
      logic [1:0]  status;
      logic [4:0]  item_total;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [63:0]      key;
      logic [3:0]       key_length;
      logic [31:0]      value;
      logic [IDX_W-1:0] home;
   } cmd_type;

   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  key_length;
      logic [31:0] value;
   } slot_entry_type;

   typedef enum logic {
      F_IDLE,
      F_HASH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_CHECK,
      B_DONE
   } back_state_type;

endpackage
`default_nettype wire

### design/open_addressing_hash_table.sv
`default_nettype none
// Key/value table of TABLE_SLOTS slots with linear probing and tombstones. Each request
// transaction is a get, put, delete or no-op on a key of up to eight bytes; every
// request yields exactly one response transaction, in order. The front hashes the key
// with 64-bit fnv-1, one byte per cycle. A request goes through acceptance, one hashing
// step per key byte, and the hand-over of the command to a two-entry queue. The front
// waits while that queue is full. The back probes the slot memory with a read and a
// check per slot visited (registered read of one single-port-read RAM), between a queue
// pop and a response post, and waits while the response register is not popped. Front
// and back overlap, so the sustained rate is set by the longer of the two. A finished
// response waits in an output register while the next request is hashed. Slot states
// sit in flip-flops and are invalid right after reset, so no clearing pass is needed.
// Puts are refused with a full status once (items + tombstones) * 100 / TABLE_SLOTS
// reaches usage_limit_pct (reset 70), or when the probe finds no tombstone or free
// slot. The user must write usage_limit_pct through the csr port only while the block
// is idle; the block itself does not enforce this.
module open_addressing_hash_table
   import oaht_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // request side
   input  wire logic       req_push,
   output logic            req_full,
   input  wire req_type    req_data,
   // response side
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output rsp_type         rsp_data,
   // usage limit register
   input  wire logic       csr_write_enable,
   input  wire logic [6:0] csr_write_data
);
   logic [6:0] usage_limit_ff;
   // front to back queue
   logic       q_push, q_full, q_pop, q_empty;
   cmd_type    q_in, q_out;

   // usage limit in percent, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         usage_limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         usage_limit_ff <= csr_write_data;
      end
   end

   // front: accepts requests, saturates the length, masks and hashes the key
   oaht_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_data  (q_in)
   );

   // short queue lets front and back stall on their own
   oaht_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .full    (q_full),
      .data_in (q_in),
      .pop     (q_pop),
      .empty   (q_empty),
      .data_out(q_out)
   );

   // back: probes the slots, applies the update, posts the response
   oaht_back u_back (
      .clock          (clock),
      .reset          (reset),
      .usage_limit_pct(usage_limit_ff),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_data         (q_out),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data)
   );
endmodule
`default_nettype wire

### design/oaht_ram.sv
`default_nettype none
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### design/oaht_queue.sv
`default_nettype none
module oaht_queue
   import oaht_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire cmd_type data_in,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      data_out
);
   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign data_out = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // depth is a power of two, pointers wrap on their own
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= data_in;
      end
   end
endmodule
`default_nettype wire

### design/oaht_front.sv
`default_nettype none
module oaht_front
   import oaht_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         q_push,
   input  wire logic    q_full,
   output cmd_type      q_data
);
   front_state_type state_ff, state_in;
   logic [1:0]  action_ff;
   logic [63:0] key_ff, key_in;
   logic [3:0]  len_ff, len_in;
   logic [31:0] value_ff;
   logic [63:0] hash_ff, hash_mul;
   logic [3:0]  cnt_ff;
   logic        accept, rounds_done;

   assign accept      = req_push && !req_full;
   assign rounds_done = (cnt_ff == len_ff);

   // saturate the length and drop bytes beyond it
   always_comb begin
      len_in = (req_data.key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES)
                                                         : req_data.key_length;
      for (int b = 0; b < 8; b++) begin
         key_in[b*8 +: 8] = (4'(b) < len_in) ? req_data.key_bytes[b*8 +: 8] : 8'h00;
      end
   end

   // fnv-1 multiply by the prime as a shift plus a small constant product
   assign hash_mul = (hash_ff << FNV_SHIFT) + hash_ff * FNV_PRIME_LO;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_HASH;
         end
         F_HASH: begin
            if (rounds_done && !q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_full        = (state_ff != F_IDLE);
      q_push          = (state_ff == F_HASH) && rounds_done;
      q_data.action     = action_ff;
      q_data.key        = key_ff;
      q_data.key_length = len_ff;
      q_data.value      = value_ff;
      q_data.home       = hash_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_data.action;
         key_ff    <= key_in;
         len_ff    <= len_in;
         value_ff  <= req_data.value;
         hash_ff   <= FNV_BASIS;
         cnt_ff    <= '0;
      end else if (state_ff == F_HASH && !rounds_done) begin
         hash_ff <= hash_mul ^ {56'h0, key_ff[cnt_ff[2:0]*8 +: 8]};
         cnt_ff  <= cnt_ff + 4'd1;
      end
   end
endmodule
`default_nettype wire

### design/oaht_back.sv
`default_nettype none
`include "open_addressing_hash_table_defines.svh"
module oaht_back
   import oaht_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [6:0] usage_limit_pct,
   input  wire logic       q_empty,
   output logic            q_pop,
   input  wire cmd_type    q_data,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output rsp_type         rsp_data
);
   back_state_type state_ff, state_in;
   cmd_type          cmd_ff;
   logic [1:0]       slot_state_ff [TABLE_SLOTS];
   logic [CNT_W-1:0] items_ff, tombs_ff;
   logic [IDX_W-1:0] step_ff, idx;
   logic             at_limit_ff;
   logic             hit_ff, tomb_seen_ff, free_seen_ff;
   logic [IDX_W-1:0] hit_idx_ff, tomb_idx_ff, free_idx_ff;
   logic [31:0]      hit_val_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   slot_entry_type   rd_entry, wr_entry;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [USED_W-1:0] used;
   logic             out_free, finish, last_step;
   logic [1:0]       cur_state;
   logic             key_match;
   // update decisions
   logic             set_tomb_a, set_valid_b;
   logic [IDX_W-1:0] tomb_a_idx, valid_b_idx;
   logic             inc_items, dec_items, inc_tombs, dec_tombs;

   oaht_ram #(
      .WIDTH($bits(slot_entry_type)),
      .DEPTH(TABLE_SLOTS)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(wr_entry),
      .rd_addr(idx),
      .rd_data(rd_entry)
   );

   assign idx       = IDX_W'(cmd_ff.home + step_ff);
   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign finish    = (state_ff == B_DONE) && out_free;
   assign last_step = (step_ff == IDX_W'(TABLE_SLOTS - 1));
   assign cur_state = slot_state_ff[idx];
   assign key_match = (rd_entry.key_length == cmd_ff.key_length) &&
                      (rd_entry.key == cmd_ff.key);
   assign used      = (USED_W'(USED_W'(items_ff) + USED_W'(tombs_ff)) * USED_W'(PCT_SCALE))
                      >> IDX_W;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) state_in = (q_data.action == ACT_NONE) ? B_DONE : B_READ;
         end
         B_READ:  state_in = B_CHECK;
         B_CHECK: begin
            if (cur_state == SLOT_INVALID) begin
               state_in = B_DONE;
            end else if (cur_state == SLOT_VALID && key_match) begin
               state_in = B_DONE;
            end else if (last_step) begin
               state_in = B_DONE;
            end else begin
               state_in = B_READ;
            end
         end
         B_DONE: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outcome of the finished probe
   always_comb begin
      rsp_in      = '0;
      set_tomb_a  = 1'b0;
      set_valid_b = 1'b0;
      tomb_a_idx  = hit_idx_ff;
      valid_b_idx = hit_idx_ff;
      inc_items   = 1'b0;
      dec_items   = 1'b0;
      inc_tombs   = 1'b0;
      dec_tombs   = 1'b0;
      rsp_in.found  = hit_ff && (cmd_ff.action != ACT_NONE);
      rsp_in.status = STATUS_OK;
      unique case (cmd_ff.action)
         ACT_GET: begin
            if (hit_ff) rsp_in.value_out = hit_val_ff;
            else        rsp_in.status    = STATUS_MISSING;
         end
         ACT_DELETE: begin
            if (hit_ff) begin
               set_tomb_a = 1'b1;
               dec_items  = 1'b1;
               inc_tombs  = 1'b1;
            end else begin
               rsp_in.status = STATUS_MISSING;
            end
         end
         ACT_PUT: begin
            priority if (at_limit_ff) begin
               rsp_in.status = STATUS_FULL;
            end else if (hit_ff) begin
               // move the key forward into the first tombstone
               set_valid_b = 1'b1;
               if (tomb_seen_ff) begin
                  set_tomb_a  = 1'b1;
                  valid_b_idx = tomb_idx_ff;
               end
            end else if (tomb_seen_ff) begin
               set_valid_b = 1'b1;
               valid_b_idx = tomb_idx_ff;
               inc_items   = 1'b1;
               dec_tombs   = 1'b1;
            end else if (free_seen_ff) begin
               set_valid_b = 1'b1;
               valid_b_idx = free_idx_ff;
               inc_items   = 1'b1;
            end else begin
               rsp_in.status = STATUS_FULL;
            end
         end
         default: ;
      endcase
      rsp_in.item_total = 5'(items_ff + (inc_items ? CNT_W'(1) : '0)
                                      - (dec_items ? CNT_W'(1) : '0));
   end

   always_comb begin
      q_pop                = (state_ff == B_IDLE) && !q_empty;
      ram_wr_en            = finish && set_valid_b;
      ram_wr_addr          = valid_b_idx;
      wr_entry.key         = cmd_ff.key;
      wr_entry.key_length  = cmd_ff.key_length;
      wr_entry.value       = cmd_ff.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         items_ff     <= '0;
         tombs_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_state_ff[s] <= SLOT_INVALID;
         end
      end else begin
         state_ff <= state_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            if (set_tomb_a)  slot_state_ff[tomb_a_idx]  <= SLOT_TOMB;
            if (set_valid_b) slot_state_ff[valid_b_idx] <= SLOT_VALID;
            items_ff <= items_ff + (inc_items ? CNT_W'(1) : '0) - (dec_items ? CNT_W'(1) : '0);
            tombs_ff <= tombs_ff + (inc_tombs ? CNT_W'(1) : '0) - (dec_tombs ? CNT_W'(1) : '0);
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff       <= q_data;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
         tomb_seen_ff <= 1'b0;
         free_seen_ff <= 1'b0;
         at_limit_ff  <= (used >= USED_W'(usage_limit_pct));
      end else if (state_ff == B_CHECK) begin
         if (cur_state == SLOT_INVALID) begin
            free_seen_ff <= 1'b1;
            free_idx_ff  <= idx;
         end else if (cur_state == SLOT_VALID && key_match) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx;
            hit_val_ff <= rd_entry.value;
         end else begin
            if (cur_state == SLOT_TOMB && !tomb_seen_ff) begin
               tomb_seen_ff <= 1'b1;
               tomb_idx_ff  <= idx;
            end
            step_ff <= step_ff + IDX_W'(1);
         end
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   `OAHT_ASSERT_NOW(a_usage_bound, 1'b1,
      (USED_W'(items_ff) + USED_W'(tombs_ff)) <= USED_W'(TABLE_SLOTS),
      "items plus tombstones exceed the slot count")
   `OAHT_ASSERT_NOW(a_full_only_put, finish && rsp_in.status == STATUS_FULL,
      cmd_ff.action == ACT_PUT, "full status on a transaction that is not a put")
   `OAHT_ASSERT_NEXT(a_finish_idle, finish, state_ff == B_IDLE && rsp_valid_ff,
      "finished transaction did not post its response")
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import oaht_pkg::*;

   // the table as the block should hold it, plus the queue of responses it owes
   class table_scoreboard;
      logic [1:0]  slot_st [TABLE_SLOTS];
      logic [63:0] slot_k [TABLE_SLOTS];
      logic [3:0]  slot_len [TABLE_SLOTS];
      logic [31:0] slot_v [TABLE_SLOTS];
      int unsigned items;
      int unsigned tombs;
      int unsigned limit_pct;
      rsp_type     owed_rsp [$];
      int          error_count;

      function new();
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_st[i] = SLOT_INVALID;
            slot_k[i] = '0;
            slot_len[i] = '0;
            slot_v[i] = '0;
         end
         items = 0;
         tombs = 0;
         limit_pct = LIMIT_RESET;
         error_count = 0;
      endfunction

      function void set_limit(logic [6:0] pct);
         limit_pct = pct;
      endfunction

      // apply one accepted request to the table model and queue its response
      function void note_request(req_type req);
         logic [63:0] key;
         logic [63:0] hash;
         int unsigned len;
         int          hit;
         int          tomb;
         int          free_idx;
         int          idx;
         int          dst;
         rsp_type     rsp;
         len = (req.key_length > MAX_KEY_BYTES) ? MAX_KEY_BYTES : req.key_length;
         key = (len >= 8) ? req.key_bytes : (req.key_bytes & ((64'd1 << (len * 8)) - 1));
         rsp = '0;
         if (req.action != ACT_NONE) begin
            hash = FNV_BASIS;
            for (int i = 0; i < len; i++) begin
               hash = hash * 64'h100000001b3;
               hash = hash ^ ((key >> (i * 8)) & 64'hff);
            end
            hit = -1;
            tomb = -1;
            free_idx = -1;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               idx = int'((hash + 64'(i)) & 64'(TABLE_SLOTS - 1));
               if (slot_st[idx] == SLOT_VALID) begin
                  if (slot_len[idx] == len && slot_k[idx] == key) begin
                     hit = idx;
                     break;
                  end
               end else if (slot_st[idx] == SLOT_TOMB) begin
                  if (tomb < 0) tomb = idx;
               end else begin
                  free_idx = idx;
                  break;
               end
            end
            rsp.found = (hit >= 0);
            if (req.action == ACT_GET) begin
               if (hit >= 0) rsp.value_out = slot_v[hit];
               else rsp.status = STATUS_MISSING;
            end else if (req.action == ACT_DELETE) begin
               if (hit >= 0) begin
                  slot_st[hit] = SLOT_TOMB;
                  items--;
                  tombs++;
               end else begin
                  rsp.status = STATUS_MISSING;
               end
            end else if ((items + tombs) * 100 / TABLE_SLOTS >= limit_pct) begin
               rsp.status = STATUS_FULL;
            end else begin
               dst = (hit >= 0) ? hit : ((tomb >= 0) ? tomb : free_idx);
               if (hit >= 0 && tomb >= 0) begin
                  // update moves the key forward into the earlier tombstone
                  slot_st[hit] = SLOT_TOMB;
                  dst = tomb;
               end
               if (dst < 0) begin
                  rsp.status = STATUS_FULL;
               end else begin
                  if (hit < 0) begin
                     if (tomb >= 0) tombs--;
                     items++;
                  end
                  slot_st[dst] = SLOT_VALID;
                  slot_k[dst] = key;
                  slot_len[dst] = 4'(len);
                  slot_v[dst] = req.value;
               end
            end
         end
         rsp.item_total = items[4:0];
         owed_rsp.push_back(rsp);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
         error_count++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (owed_rsp.size() == 0) begin
            $display("unexpected response transaction at %0t", $realtime);
            error_count++;
            return;
         end
         want = owed_rsp.pop_front();
         if (got.found !== want.found) report_mismatch("found", got.found, want.found);
         if (got.value_out !== want.value_out)
            report_mismatch("value_out", got.value_out, want.value_out);
         if (got.status !== want.status) report_mismatch("status", got.status, want.status);
         if (got.item_total !== want.item_total)
            report_mismatch("item_total", got.item_total, want.item_total);
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   req_type    req_data;
   logic       rsp_empty;
   logic       rsp_pop;
   rsp_type    rsp_data;
   logic       csr_write_enable;
   logic [6:0] csr_write_data;

   table_scoreboard board;
   bit          stim_done;
   bit          random_gaps;   // off during stretches with no idling
   int          hold_cycles;   // long receiver hold-off requested by the sender

   open_addressing_hash_table DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // small key pool so that puts, gets and deletes collide on the same keys
   logic [63:0] key_pool [12];
   logic [3:0]  len_pool [12];

   function automatic req_type pool_request(logic [1:0] act);
      req_type r;
      int      k;
      k = $urandom_range(11);
      r.action = act;
      r.key_bytes = key_pool[k];
      r.key_length = len_pool[k];
      // bytes beyond the length are noise and must be ignored
      if (len_pool[k] < 8 && $urandom_range(3) == 0)
         r.key_bytes = r.key_bytes | ({$urandom, $urandom} << (len_pool[k] * 8));
      if (len_pool[k] == 8 && $urandom_range(3) == 0)
         r.key_length = 4'(8 + $urandom_range(7));
      r.value = $urandom;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 85) begin
         pick = $urandom_range(99);
         if (pick < 40) r = pool_request(ACT_PUT);
         else if (pick < 75) r = pool_request(ACT_GET);
         else r = pool_request(ACT_DELETE);
      end else begin
         // noise: any key, any length, any action code
         r.action = 2'($urandom_range(3));
         r.key_bytes = {$urandom, $urandom};
         r.key_length = 4'($urandom_range(15));
         r.value = $urandom;
      end
      return r;
   endfunction

   // one request transaction: idle a random gap, then push until accepted
   task automatic send_request(req_type r, bit gap);
      int wait_cycles;
      wait_cycles = (gap && random_gaps) ? $urandom_range(17) : 0;
      if (wait_cycles != 0) begin
         req_push <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic drain_responses();
      req_push <= 1'b0;
      while (board.owed_rsp.size() != 0) @(posedge clock);
      // a response can be popped while the back still finishes; let it settle
      repeat (2 * TABLE_SLOTS + 16) @(posedge clock);
   endtask

   task automatic write_limit(logic [6:0] pct);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data <= pct;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_limit(pct);
   endtask

   task automatic directed_requests();
      req_type r;
      // miss on empty table, unused action code, extreme keys and lengths
      r = '{action: ACT_GET, key_bytes: 64'hffff_ffff_ffff_ffff, key_length: 4'd8,
            value: 32'd0};
      send_request(r, 1'b1);
      r = '{action: ACT_NONE, key_bytes: 64'h0, key_length: 4'd0, value: 32'hffffffff};
      send_request(r, 1'b1);
      r = '{action: ACT_PUT, key_bytes: 64'h0, key_length: 4'd0, value: 32'hffffffff};
      send_request(r, 1'b1);
      r = '{action: ACT_PUT, key_bytes: 64'hffff_ffff_ffff_ffff, key_length: 4'd15,
            value: 32'h0};
      send_request(r, 1'b1);
      // long length saturates: same key as the one just stored
      r = '{action: ACT_GET, key_bytes: 64'hffff_ffff_ffff_ffff, key_length: 4'd8,
            value: 32'h0};
      send_request(r, 1'b1);
      // empty key ignores all key bytes
      r = '{action: ACT_GET, key_bytes: 64'h1234_5678_9abc_def0, key_length: 4'd0,
            value: 32'h0};
      send_request(r, 1'b1);
      // update of a present key
      r = '{action: ACT_PUT, key_bytes: 64'hdead_00ab, key_length: 4'd1, value: 32'h5a5a};
      send_request(r, 1'b1);
      r = '{action: ACT_PUT, key_bytes: 64'hab, key_length: 4'd1, value: 32'ha5a5};
      send_request(r, 1'b1);
      r = '{action: ACT_GET, key_bytes: 64'h77ab, key_length: 4'd1, value: 32'h0};
      send_request(r, 1'b1);
      // delete hit, delete miss, get after delete
      r = '{action: ACT_DELETE, key_bytes: 64'hab, key_length: 4'd1, value: 32'h0};
      send_request(r, 1'b1);
      send_request(r, 1'b1);
      r.action = ACT_GET;
      send_request(r, 1'b1);
      // put reuses the tombstone
      r = '{action: ACT_PUT, key_bytes: 64'hab, key_length: 4'd1, value: 32'h1111};
      send_request(r, 1'b1);
      // fill until the limit refuses puts, including an update of a present key
      for (int i = 0; i < 12; i++) begin
         r = '{action: ACT_PUT, key_bytes: 64'h100 + i, key_length: 4'd2, value: i};
         send_request(r, 1'b0);
      end
      r = '{action: ACT_PUT, key_bytes: 64'hab, key_length: 4'd1, value: 32'h2222};
      send_request(r, 1'b0);
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_request(random_request(), 1'b1);
   endtask

   // sender
   initial begin
      req_type r;
      board = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      stim_done = 1'b0;
      random_gaps = 1'b1;
      hold_cycles = 0;
      for (int i = 0; i < 12; i++) begin
         len_pool[i] = (i < 9) ? 4'(i) : 4'($urandom_range(1, 8));
         key_pool[i] = {$urandom, $urandom};
         if (len_pool[i] < 8)
            key_pool[i] = key_pool[i] & ((64'd1 << (len_pool[i] * 8)) - 1);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_requests();

      // full path with the limit off: saturated probe refuses puts
      write_limit(7'd127);
      for (int i = 0; i < 20; i++) begin
         r = '{action: ACT_PUT, key_bytes: 64'h9000 + i, key_length: 4'd3, value: i};
         send_request(r, 1'b0);
      end
      r = '{action: ACT_GET, key_bytes: 64'h9013, key_length: 4'd3, value: 0};
      send_request(r, 1'b0);
      // delete a few of those keys, then run random requests over the fresh tombstones
      for (int i = 0; i < 16; i += 3) begin
         r = '{action: ACT_DELETE, key_bytes: 64'h9000 + i, key_length: 4'd3, value: 0};
         send_request(r, 1'b0);
      end
      random_phase(80);

      // every put refused
      write_limit(7'd0);
      random_phase(60);

      // lowest limit, then mid values; the table keeps its contents between phases
      write_limit(7'd1);
      random_phase(60);

      // pause until everything is back, then keep the receiver off for a while
      drain_responses();
      hold_cycles = 150;
      random_gaps = 1'b0;
      random_phase(40);
      random_gaps = 1'b1;

      write_limit(7'd100);
      random_phase(250);
      write_limit(7'd50);
      random_phase(200);
      write_limit(7'd90);
      random_phase(200);
      write_limit(7'd70);
      random_gaps = 1'b0;
      random_phase(100);
      random_gaps = 1'b1;
      random_phase(100);

      drain_responses();
      stim_done = 1'b1;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_cycles != 0) begin
            rsp_pop <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = random_gaps ? $urandom_range(17) : 0;
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         // transaction accepted on this edge
         board.check_response(rsp_data);
      end
   end

   // final verdict
   initial begin
      wait (stim_done);
      if (board.error_count == 0 && board.owed_rsp.size() == 0) begin
         $display("open_addressing_hash_table test passed");
      end else begin
         $display("open_addressing_hash_table test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("open_addressing_hash_table test failed");
      $finish;
   end

endmodule

`default_nettype wire
